/* hdl/wpsr_pkg.sv */
// ============================================================================
// wpsr_pkg
// Shared types and constants for the water phase source rate pipeline.
// ============================================================================
`default_nettype none

package wpsr_pkg;

    // Register map, word index = paddr[2]
    localparam logic REG_TIME_STEP = 1'b0;
    localparam logic [31:0] TIME_STEP_RESET = 32'd3932160;

    // Temperature limits and melting point, Q9.16 kelvin
    localparam logic [24:0] T_LOW  = 25'd9830400;
    localparam logic [24:0] T_HIGH = 25'd22937600;
    localparam logic [24:0] T_MELT = 25'd17901158;

    // Magnus coefficients, Q16
    localparam logic [20:0] WATER_A = 21'd1154744;
    localparam logic [24:0] WATER_B = 25'd15933112;
    localparam logic [20:0] ICE_A   = 21'd1471939;
    localparam logic [24:0] ICE_B   = 25'd17866424;

    // ln2 in Q32 and saturation density scale
    localparam logic [31:0] LN2       = 32'd2977044472;
    localparam logic [24:0] SAT_SCALE = 25'd22218162;

    // Latent heats, J/kg
    localparam logic [21:0] HEAT_VAP = 22'd2257000;
    localparam logic [21:0] HEAT_FUS = 22'd333500;
    localparam logic [21:0] HEAT_SUB = 22'd2590500;
    localparam int MASS_SHIFT = 16;

    // Datapath widths
    localparam int X_QW    = 37;  // |x| quotient bits, Q32
    localparam int EXP_NB  = 6;   // bits of n = floor(|x| / ln2)
    localparam int TERMS   = 13;  // Taylor terms after the constant one
    localparam int E_W     = 41;  // exp result
    localparam int SAT_W   = 41;  // saturation density quotient bits
    localparam int NUM_W   = 74;  // rate numerators, signed
    localparam int RATE_QW = 63;  // rate quotient bits
    localparam int RATE_N  = 5;   // number of rate lanes

    localparam logic signed [63:0] RATE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] RATE_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [47:0] ice_density;
        logic [47:0] liquid_density;
        logic [47:0] vapour_density;
        logic [24:0] air_temperature;
        logic        last_cell;
    } t_cell_in;

    typedef struct packed {
        logic signed [63:0] ice_mass_rate;
        logic signed [63:0] liquid_mass_rate;
        logic signed [63:0] vapour_mass_rate;
        logic signed [63:0] ice_heat_rate;
        logic signed [63:0] liquid_heat_rate;
        logic               last_cell_out;
    } t_result_out;

    // Cell data that rides along the saturation pipeline
    typedef struct packed {
        logic [47:0] rho_i;
        logic [47:0] rho_l;
        logic [47:0] rho_v;
        logic [24:0] tq;
        logic        warm;
        logic        last;
    } t_carry;

    // Per-word control through the Taylor series
    typedef struct packed {
        logic [31:0] r;
        logic [6:0]  nn;
        logic        up;
        t_carry      c;
    } t_exp_ctl;

endpackage

`default_nettype wire

/* hdl/wpsr_magnus.sv */
// ============================================================================
// wpsr_magnus
// Saturation vapour density per cell: clamp, Magnus exponent by a pipelined
// divider, exp by range reduction and Taylor series, scale and divide by T.
// ============================================================================
`default_nettype none

module wpsr_magnus (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  wpsr_pkg::t_cell_in i_cell,
    output logic              o_valid,
    output logic [wpsr_pkg::SAT_W-1:0] o_sat,
    output wpsr_pkg::t_carry  o_carry
);
    import wpsr_pkg::*;

    // ------------------------------------------------------------------
    // Stage 1: clamp, signed offset from melting point, coefficient pick
    // ------------------------------------------------------------------
    logic [24:0]        w_tq;
    logic signed [25:0] w_t;
    logic signed [25:0] w_den_s;
    logic               w_warm;
    logic [22:0]        w_at;
    t_carry             w_c;

    always_comb begin
        if (i_cell.air_temperature < T_LOW) begin
            w_tq = T_LOW;
        end else if (i_cell.air_temperature > T_HIGH) begin
            w_tq = T_HIGH;
        end else begin
            w_tq = i_cell.air_temperature;
        end
        w_t     = $signed({1'b0, w_tq}) - $signed({1'b0, T_MELT});
        w_warm  = !w_t[25];
        w_at    = w_warm ? w_t[22:0] : 23'(-w_t);
        w_den_s = $signed({1'b0, (w_warm ? WATER_B : ICE_B)}) + w_t;
        w_c.rho_i = i_cell.ice_density;
        w_c.rho_l = i_cell.liquid_density;
        w_c.rho_v = i_cell.vapour_density;
        w_c.tq    = w_tq;
        w_c.warm  = w_warm;
        w_c.last  = i_cell.last_cell;
    end

    logic        r_s1_v;
    logic [20:0] r_s1_a;
    logic [22:0] r_s1_at;
    logic [24:0] r_s1_den;
    t_carry      r_s1_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_a   <= w_warm ? WATER_A : ICE_A;
        r_s1_at  <= w_at;
        r_s1_den <= w_den_s[24:0];
        r_s1_c   <= w_c;
    end

    // ------------------------------------------------------------------
    // |x| = (a*|t| << 16) / den, one quotient bit per stage
    // ------------------------------------------------------------------
    logic [43:0] w_num;
    assign w_num = {23'b0, r_s1_a} * {21'b0, r_s1_at};

    logic              r_xv   [X_QW+1];
    logic [43:0]       r_xnum [X_QW+1];
    logic [24:0]       r_xrem [X_QW+1];
    logic [X_QW-1:0]   r_xq   [X_QW+1];
    logic [24:0]       r_xden [X_QW+1];
    t_carry            r_xc   [X_QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xv[0] <= 1'b0;
        end else begin
            r_xv[0] <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xnum[0] <= w_num;
        r_xrem[0] <= {2'b0, w_num[43:21]};
        r_xq[0]   <= '0;
        r_xden[0] <= r_s1_den;
        r_xc[0]   <= r_s1_c;
    end

    for (genvar j = 0; j < X_QW; j++) begin : g_xdiv
        localparam int BI = X_QW - 1 - j;
        logic [59:0] w_n60;
        logic [25:0] w_sh;
        logic        w_ge;

        always_comb begin
            w_n60 = {r_xnum[j], 16'b0};
            w_sh  = {r_xrem[j], w_n60[BI]};
            w_ge  = w_sh >= {1'b0, r_xden[j]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_xv[j+1] <= 1'b0;
            end else begin
                r_xv[j+1] <= r_xv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_xnum[j+1] <= r_xnum[j];
            r_xrem[j+1] <= w_ge ? 25'(w_sh - {1'b0, r_xden[j]}) : w_sh[24:0];
            r_xq[j+1]   <= {r_xq[j][X_QW-2:0], w_ge};
            r_xden[j+1] <= r_xden[j];
            r_xc[j+1]   <= r_xc[j];
        end
    end

    // ------------------------------------------------------------------
    // Range reduction: |x| = n*ln2 + rem, one bit of n per stage
    // ------------------------------------------------------------------
    logic              r_ev   [EXP_NB+1];
    logic [X_QW-1:0]   r_erem [EXP_NB+1];
    logic [EXP_NB-1:0] r_en   [EXP_NB+1];
    t_carry            r_ec   [EXP_NB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev[0] <= 1'b0;
        end else begin
            r_ev[0] <= r_xv[X_QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_erem[0] <= r_xq[X_QW];
        r_en[0]   <= '0;
        r_ec[0]   <= r_xc[X_QW];
    end

    for (genvar i = 0; i < EXP_NB; i++) begin : g_ered
        localparam logic [X_QW:0] LK = (X_QW+1)'(LN2) << (EXP_NB - 1 - i);
        logic w_ge;

        assign w_ge = {1'b0, r_erem[i]} >= LK;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ev[i+1] <= 1'b0;
            end else begin
                r_ev[i+1] <= r_ev[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_erem[i+1] <= w_ge ? X_QW'({1'b0, r_erem[i]} - LK) : r_erem[i];
            r_en[i+1]   <= {r_en[i][EXP_NB-2:0], w_ge};
            r_ec[i+1]   <= r_ec[i];
        end
    end

    // Negative x: round n up so the residue stays in [0, ln2)
    t_exp_ctl w_ctl0;

    always_comb begin
        w_ctl0.c  = r_ec[EXP_NB];
        w_ctl0.up = r_ec[EXP_NB].warm;
        if (!r_ec[EXP_NB].warm && (r_erem[EXP_NB] != '0)) begin
            w_ctl0.nn = 7'(r_en[EXP_NB]) + 7'd1;
            w_ctl0.r  = LN2 - r_erem[EXP_NB][31:0];
        end else if (!r_ec[EXP_NB].warm) begin
            w_ctl0.nn = 7'(r_en[EXP_NB]);
            w_ctl0.r  = '0;
        end else begin
            w_ctl0.nn = 7'(r_en[EXP_NB]);
            w_ctl0.r  = r_erem[EXP_NB][31:0];
        end
    end

    // ------------------------------------------------------------------
    // Taylor series of exp(r): three stages per term
    //   a: term * r, b: times reciprocal of k, c: correct and accumulate
    // ------------------------------------------------------------------
    logic        r_tv   [TERMS+1];
    logic [32:0] r_term [TERMS+1];
    logic [33:0] r_sum  [TERMS+1];
    t_exp_ctl    r_tctl [TERMS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv[0] <= 1'b0;
        end else begin
            r_tv[0] <= r_ev[EXP_NB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_term[0] <= 33'h1_0000_0000;
        r_sum[0]  <= 34'h1_0000_0000;
        r_tctl[0] <= w_ctl0;
    end

    for (genvar i = 0; i < TERMS; i++) begin : g_term
        localparam logic [3:0]  K  = 4'(i + 1);
        localparam logic [35:0] MK = 36'((64'd1 << 35) / (i + 1));

        logic [63:0] w_prod;
        logic [67:0] w_mq;
        logic [31:0] w_qk;
        logic [31:0] w_rem;
        logic [31:0] w_q;

        logic        r_av;
        logic [31:0] r_aps;
        logic [33:0] r_asum;
        t_exp_ctl    r_actl;
        logic        r_bv;
        logic [31:0] r_bps;
        logic [31:0] r_bqe;
        logic [33:0] r_bsum;
        t_exp_ctl    r_bctl;

        always_comb begin
            w_prod = 64'(r_term[i]) * 64'(r_tctl[i].r);
            w_mq   = 68'(r_aps) * 68'(MK);
            w_qk   = r_bqe * 32'(K);
            w_rem  = r_bps - w_qk;
            w_q    = r_bqe + 32'(w_rem >= 32'(K));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_av      <= 1'b0;
                r_bv      <= 1'b0;
                r_tv[i+1] <= 1'b0;
            end else begin
                r_av      <= r_tv[i];
                r_bv      <= r_av;
                r_tv[i+1] <= r_bv;
            end
        end

        always_ff @(posedge i_clk) begin
            r_aps       <= w_prod[63:32];
            r_asum      <= r_sum[i];
            r_actl      <= r_tctl[i];
            r_bps       <= r_aps;
            r_bqe       <= w_mq[66:35];
            r_bsum      <= r_asum;
            r_bctl      <= r_actl;
            r_term[i+1] <= {1'b0, w_q};
            r_sum[i+1]  <= r_bsum + 34'(w_q);
            r_tctl[i+1] <= r_bctl;
        end
    end

    // ------------------------------------------------------------------
    // Undo range reduction: shift by n
    // ------------------------------------------------------------------
    logic           r_shv;
    logic [E_W-1:0] r_she;
    t_carry         r_shc;
    logic [E_W-1:0] w_e;

    always_comb begin
        if (r_tctl[TERMS].up) begin
            w_e = (r_tctl[TERMS].nn < 7'd8) ?
                  (E_W'(r_sum[TERMS]) << r_tctl[TERMS].nn[2:0]) : '0;
        end else begin
            w_e = E_W'(r_sum[TERMS] >> r_tctl[TERMS].nn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shv <= 1'b0;
        end else begin
            r_shv <= r_tv[TERMS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_she <= w_e;
        r_shc <= r_tctl[TERMS].c;
    end

    // ------------------------------------------------------------------
    // Saturation density = E * scale / T, one quotient bit per stage
    // ------------------------------------------------------------------
    logic [63:0] w_sp;
    assign w_sp = 64'(r_she) * 64'(SAT_SCALE);

    logic             r_sv   [SAT_W+1];
    logic [63:0]      r_snum [SAT_W+1];
    logic [24:0]      r_srem [SAT_W+1];
    logic [SAT_W-1:0] r_sq   [SAT_W+1];
    t_carry           r_sc   [SAT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else begin
            r_sv[0] <= r_shv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_snum[0] <= w_sp;
        r_srem[0] <= {2'b0, w_sp[63:SAT_W]};
        r_sq[0]   <= '0;
        r_sc[0]   <= r_shc;
    end

    for (genvar j = 0; j < SAT_W; j++) begin : g_sdiv
        localparam int BI = SAT_W - 1 - j;
        logic [25:0] w_sh;
        logic        w_ge;

        always_comb begin
            w_sh = {r_srem[j], r_snum[j][BI]};
            w_ge = w_sh >= {1'b0, r_sc[j].tq};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j+1] <= 1'b0;
            end else begin
                r_sv[j+1] <= r_sv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_snum[j+1] <= r_snum[j];
            r_srem[j+1] <= w_ge ? 25'(w_sh - {1'b0, r_sc[j].tq}) : w_sh[24:0];
            r_sq[j+1]   <= {r_sq[j][SAT_W-2:0], w_ge};
            r_sc[j+1]   <= r_sc[j];
        end
    end

    assign o_valid = r_sv[SAT_W];
    assign o_sat   = r_sq[SAT_W];
    assign o_carry = r_sc[SAT_W];

endmodule

`default_nettype wire

/* hdl/wpsr_rates.sv */
// ============================================================================
// wpsr_rates
// Five signed numerators divided by the time step: truncation toward zero,
// saturation to int64, one quotient bit per stage in each lane.
// ============================================================================
`default_nettype none

module wpsr_rates (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [wpsr_pkg::NUM_W-1:0] i_num [wpsr_pkg::RATE_N],
    input  logic                          i_last,
    input  logic [31:0]                   i_div,
    output logic                          o_valid,
    output wpsr_pkg::t_result_out         o_result
);
    import wpsr_pkg::*;

    logic                 r_v    [RATE_QW+1];
    logic                 r_last [RATE_QW+1];
    logic                 r_neg  [RATE_N][RATE_QW+1];
    logic                 r_sat  [RATE_N][RATE_QW+1];
    logic [RATE_QW-1:0]   r_mag  [RATE_N][RATE_QW+1];
    logic [31:0]          r_rem  [RATE_N][RATE_QW+1];
    logic [RATE_QW-1:0]   r_q    [RATE_N][RATE_QW+1];
    logic signed [63:0]   r_res  [RATE_N];

    // Valid and last ride beside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last[0] <= i_last;
    end

    for (genvar j = 0; j < RATE_QW; j++) begin : g_ctl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_last[j+1] <= r_last[j];
        end
    end

    for (genvar l = 0; l < RATE_N; l++) begin : g_lane
        logic [NUM_W-2:0] w_mag;
        logic [31:0]      w_top;

        // Magnitude and early overflow test: |n| >> 63 >= divisor
        always_comb begin
            w_mag = i_num[l][NUM_W-1] ? (NUM_W-1)'(-i_num[l]) : i_num[l][NUM_W-2:0];
            w_top = 32'(w_mag[NUM_W-2:RATE_QW]);
        end

        always_ff @(posedge i_clk) begin
            r_neg[l][0] <= i_num[l][NUM_W-1];
            r_sat[l][0] <= w_top >= i_div;
            r_mag[l][0] <= w_mag[RATE_QW-1:0];
            r_rem[l][0] <= w_top;
            r_q[l][0]   <= '0;
        end

        for (genvar j = 0; j < RATE_QW; j++) begin : g_step
            localparam int BI = RATE_QW - 1 - j;
            logic [32:0] w_sh;
            logic        w_ge;

            always_comb begin
                w_sh = {r_rem[l][j], r_mag[l][j][BI]};
                w_ge = w_sh >= {1'b0, i_div};
            end

            always_ff @(posedge i_clk) begin
                r_neg[l][j+1] <= r_neg[l][j];
                r_sat[l][j+1] <= r_sat[l][j];
                r_mag[l][j+1] <= r_mag[l][j];
                r_rem[l][j+1] <= w_ge ? 32'(w_sh - {1'b0, i_div}) : w_sh[31:0];
                r_q[l][j+1]   <= {r_q[l][j][RATE_QW-2:0], w_ge};
            end
        end

        // Sign and clip
        always_ff @(posedge i_clk) begin
            if (r_sat[l][RATE_QW]) begin
                r_res[l] <= r_neg[l][RATE_QW] ? RATE_MIN : RATE_MAX;
            end else if (r_neg[l][RATE_QW]) begin
                r_res[l] <= -$signed({1'b0, r_q[l][RATE_QW]});
            end else begin
                r_res[l] <= $signed({1'b0, r_q[l][RATE_QW]});
            end
        end
    end

    logic r_ov;
    logic r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[RATE_QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_olast <= r_last[RATE_QW];
    end

    assign o_valid                   = r_ov;
    assign o_result.ice_mass_rate    = r_res[0];
    assign o_result.liquid_mass_rate = r_res[1];
    assign o_result.vapour_mass_rate = r_res[2];
    assign o_result.ice_heat_rate    = r_res[3];
    assign o_result.liquid_heat_rate = r_res[4];
    assign o_result.last_cell_out    = r_olast;

endmodule

`default_nettype wire

/* hdl/water_phase_source_rates.sv */
// ============================================================================
// water_phase_source_rates_core
// Phase-change mass and latent heat rates of water per grid cell, from the
// Magnus saturation density, divided by the configured time step.
// ============================================================================
//
//  channel   | handshake                        | word
//  ----------+----------------------------------+--------------------------
//  cell in   | start, busy (always low)         | i_cell   (t_cell_in)
//  result    | o_result_valid, one-cycle strobe | o_result (t_result_out)
//  config    | APB psel/penable/pwrite, pready  | time_step at paddr 0
//
//  One word enters per clock; the result strobes at the end of the register
//  chain (magnus divider, 13-term exp, density divider, rate dividers: one
//  quotient bit per stage).
//  Synchronous active-low reset clears every valid bit and sets time_step
//  to 60 s. Nothing stalls: busy is held low and results cannot be held off.
// ============================================================================
`default_nettype none

module water_phase_source_rates_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   start,
    input  wpsr_pkg::t_cell_in     i_cell,
    output logic                   busy,
    output wpsr_pkg::t_result_out  o_result,
    output logic                   o_result_valid
);
    import wpsr_pkg::*;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [31:0] r_time_step;
    logic [31:0] w_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_TIME_STEP)) begin
            r_time_step <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_TIME_STEP) ? r_time_step : '0;
    assign pready = 1'b1;
    assign busy   = 1'b0;

    // zero time step counts as one LSB
    assign w_div = (r_time_step == '0) ? 32'd1 : r_time_step;

    // ------------------------------------------------------------------
    // Saturation density
    // ------------------------------------------------------------------
    logic             w_mv;
    logic [SAT_W-1:0] w_sat;
    t_carry           w_mc;

    wpsr_magnus u_magnus (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_cell  (i_cell),
        .o_valid (w_mv),
        .o_sat   (w_sat),
        .o_carry (w_mc)
    );

    // ------------------------------------------------------------------
    // Deficit and phase amount
    // ------------------------------------------------------------------
    logic signed [49:0] w_d;
    logic signed [49:0] w_cond;
    logic signed [49:0] w_p;

    always_comb begin
        w_d    = $signed({9'b0, w_sat}) - $signed({2'b0, w_mc.rho_v});
        w_cond = $signed({2'b0, (w_mc.warm ? w_mc.rho_l : w_mc.rho_i)});
        if (w_d[49]) begin
            w_p = w_d;
        end else if (w_d < w_cond) begin
            w_p = w_d;
        end else begin
            w_p = w_cond;
        end
    end

    logic               r_dv;
    logic signed [49:0] r_dp;
    t_carry             r_dc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else begin
            r_dv <= w_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dp <= w_p;
        r_dc <= w_mc;
    end

    // ------------------------------------------------------------------
    // Latent heat products
    // ------------------------------------------------------------------
    logic signed [NUM_W-1:0] w_p74;
    logic signed [NUM_W-1:0] w_lat;
    logic signed [NUM_W-1:0] w_fus;

    always_comb begin
        w_p74 = NUM_W'(r_dp);
        w_lat = w_p74 * $signed(NUM_W'(r_dc.warm ? HEAT_VAP : HEAT_SUB));
        w_fus = $signed(NUM_W'(r_dc.warm ? r_dc.rho_i : r_dc.rho_l))
              * $signed(NUM_W'(HEAT_FUS));
    end

    logic                    r_nv;
    logic signed [NUM_W-1:0] r_np;
    logic signed [NUM_W-1:0] r_nlat;
    logic signed [NUM_W-1:0] r_nfus;
    t_carry                  r_nc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= 1'b0;
        end else begin
            r_nv <= r_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_np   <= w_p74;
        r_nlat <= w_lat;
        r_nfus <= w_fus;
        r_nc   <= r_dc;
    end

    // ------------------------------------------------------------------
    // Rate numerators, warm and cold cases
    // ------------------------------------------------------------------
    logic signed [NUM_W-1:0] w_ri;
    logic signed [NUM_W-1:0] w_rl;
    logic signed [NUM_W-1:0] w_num [RATE_N];

    always_comb begin
        w_ri = $signed(NUM_W'(r_nc.rho_i));
        w_rl = $signed(NUM_W'(r_nc.rho_l));
        w_num[2] = r_np <<< MASS_SHIFT;
        if (r_nc.warm) begin
            w_num[0] = -(w_ri <<< MASS_SHIFT);
            w_num[1] = (w_ri - r_np) <<< MASS_SHIFT;
            w_num[3] = -r_nfus;
            w_num[4] = -r_nlat;
        end else begin
            w_num[0] = (w_rl - r_np) <<< MASS_SHIFT;
            w_num[1] = -(w_rl <<< MASS_SHIFT);
            w_num[3] = r_nfus - r_nlat;
            w_num[4] = '0;
        end
    end

    logic                    r_rv;
    logic signed [NUM_W-1:0] r_rnum [RATE_N];
    logic                    r_rlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else begin
            r_rv <= r_nv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rnum  <= w_num;
        r_rlast <= r_nc.last;
    end

    // ------------------------------------------------------------------
    // Division by the time step
    // ------------------------------------------------------------------
    wpsr_rates u_rates (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_rv),
        .i_num    (r_rnum),
        .i_last   (r_rlast),
        .i_div    (w_div),
        .o_valid  (o_result_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
